>>> rtl/sba_pkg.sv
// Package for the scene bounds accumulator: payload structs, mode codes,
// default widths and the pipeline control struct.
// No dependencies.
`default_nettype none

package sba_pkg;

    // Width of every coordinate field on the ports.
    localparam int FIELD_W = 32;

    // Defaults for the top-level parameters.
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Item modes.
    localparam logic [2:0] MODE_CLEAR = 3'd0;
    localparam logic [2:0] MODE_POINT = 3'd1;
    localparam logic [2:0] MODE_SPHERE = 3'd2;
    localparam logic [2:0] MODE_AXIAL = 3'd3;
    localparam logic [2:0] MODE_ROW_LOAD = 3'd4;
    localparam logic [2:0] MODE_INST_BOX = 3'd5;

    // Number of matrix rows; a row index at or above this is ignored.
    localparam logic [1:0] MATRIX_ROWS = 2'd3;

    typedef struct packed {
        logic [2:0]                 mode;
        logic [1:0]                 matrix_row;
        logic signed [FIELD_W-1:0]  pos_x;
        logic signed [FIELD_W-1:0]  pos_y;
        logic signed [FIELD_W-1:0]  pos_z;
        logic signed [FIELD_W-1:0]  aux_x;
        logic signed [FIELD_W-1:0]  aux_y;
        logic signed [FIELD_W-1:0]  aux_z;
        logic signed [FIELD_W-1:0]  radius;
        logic signed [FIELD_W-1:0]  height;
    } sba_in_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0]  min_x;
        logic signed [FIELD_W-1:0]  min_y;
        logic signed [FIELD_W-1:0]  min_z;
        logic signed [FIELD_W-1:0]  max_x;
        logic signed [FIELD_W-1:0]  max_y;
        logic signed [FIELD_W-1:0]  max_z;
        logic                       is_empty;
    } sba_out_t;

    // Load strobes for the three pipeline register groups.
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic load_out;
    } sba_ctl_t;

endpackage

`default_nettype wire

>>> rtl/sba_lane.sv
// One axis lane of the scene bounds accumulator: products, then the item's
// lower and upper corner on this axis. Depends on sba_pkg.
`default_nettype none

module sba_lane #(
    parameter int COORD_WIDTH = sba_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = sba_pkg::FRAC_BITS_DEF,
    parameter int LANE        = 0
) (
    input  wire logic                          aclk,
    input  wire sba_pkg::sba_ctl_t             ctl,
    input  wire logic [2:0]                    mode,
    input  wire logic [2:0][COORD_WIDTH-1:0]   pos_v,
    input  wire logic [2:0][COORD_WIDTH-1:0]   aux_v,
    input  wire logic [COORD_WIDTH-1:0]        rad,
    input  wire logic [COORD_WIDTH-1:0]        half,
    input  wire logic [3:0][COORD_WIDTH-1:0]   mrow,
    output logic [COORD_WIDTH-1:0]             lo,
    output logic [COORD_WIDTH-1:0]             hi
);
    import sba_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int PW = 2 * CW;
    localparam int SW = PW + 2;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    function automatic logic signed [CW-1:0] sat_c(input logic signed [SW-1:0] v);
        logic signed [CW-1:0] r;
        if (v > SW'(CMAX)) begin
            r = CMAX;
        end else if (v < SW'(CMIN)) begin
            r = CMIN;
        end else begin
            r = CW'(v);
        end
        return r;
    endfunction

    // Stage A registers: raw products and the values stage B needs.
    logic [2:0]             mode_a_reg;
    logic signed [CW-1:0]   pos_a_reg;
    logic signed [CW-1:0]   rad_a_reg;
    logic signed [CW-1:0]   m3_a_reg;
    logic signed [PW-1:0]   pp_reg [3];
    logic signed [PW-1:0]   pq_reg [3];
    logic signed [PW-1:0]   pp_next [3];
    logic signed [PW-1:0]   pq_next [3];

    // Multipliers: the axial offset shares the first one.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            if (mode == MODE_AXIAL && j == 0) begin
                pp_next[j] = PW'($signed(aux_v[LANE])) * PW'($signed(half));
            end else begin
                pp_next[j] = PW'($signed(mrow[j])) * PW'($signed(pos_v[j]));
            end
            pq_next[j] = PW'($signed(mrow[j])) * PW'($signed(aux_v[j]));
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_a) begin
            mode_a_reg <= mode;
            pos_a_reg  <= $signed(pos_v[LANE]);
            rad_a_reg  <= $signed(rad);
            m3_a_reg   <= $signed(mrow[3]);
            for (int j = 0; j < 3; j++) begin
                pp_reg[j] <= pp_next[j];
                pq_reg[j] <= pq_next[j];
            end
        end
    end

    // Stage B: corner of the item on this axis.
    logic signed [SW-1:0] pos_e;
    logic signed [SW-1:0] rad_e;
    logic signed [SW-1:0] off_e;
    logic signed [CW-1:0] p0;
    logic signed [CW-1:0] p1;
    logic signed [CW-1:0] pa;
    logic signed [CW-1:0] pb;
    logic signed [SW-1:0] sum_lo;
    logic signed [SW-1:0] sum_hi;
    logic signed [PW-1:0] sp;
    logic signed [PW-1:0] sq;
    logic signed [CW-1:0] lo_next;
    logic signed [CW-1:0] hi_next;
    logic signed [CW-1:0] lo_reg;
    logic signed [CW-1:0] hi_reg;

    always_comb begin
        pos_e = SW'(pos_a_reg);
        rad_e = SW'(rad_a_reg);
        off_e = SW'(pp_reg[0] >>> FRAC_BITS);
        p0 = sat_c(pos_e - off_e);
        p1 = sat_c(pos_e + off_e);
        pa = (p0 < p1) ? p0 : p1;
        pb = (p0 < p1) ? p1 : p0;

        // Each corner picks per axis, so the extremes add term by term.
        sum_lo = SW'(m3_a_reg);
        sum_hi = SW'(m3_a_reg);
        for (int j = 0; j < 3; j++) begin
            sp = pp_reg[j] >>> FRAC_BITS;
            sq = pq_reg[j] >>> FRAC_BITS;
            sum_lo = sum_lo + SW'((sp < sq) ? sp : sq);
            sum_hi = sum_hi + SW'((sp < sq) ? sq : sp);
        end

        unique case (mode_a_reg)
            MODE_SPHERE: begin
                lo_next = sat_c(pos_e - rad_e);
                hi_next = sat_c(pos_e + rad_e);
            end
            MODE_AXIAL: begin
                lo_next = sat_c(SW'(pa) - rad_e);
                hi_next = sat_c(SW'(pb) + rad_e);
            end
            MODE_INST_BOX: begin
                lo_next = sat_c(sum_lo);
                hi_next = sat_c(sum_hi);
            end
            default: begin
                lo_next = pos_a_reg;
                hi_next = pos_a_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_b) begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule

`default_nettype wire

>>> rtl/sba_merge.sv
// Merge stage of the scene bounds accumulator: folds the three lane corners
// into the scene box and empty flag. Depends on sba_pkg.
`default_nettype none

module sba_merge #(
    parameter int COORD_WIDTH = sba_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire sba_pkg::sba_ctl_t             ctl,
    input  wire logic [2:0]                    mode,
    input  wire logic [2:0][COORD_WIDTH-1:0]   lo_v,
    input  wire logic [2:0][COORD_WIDTH-1:0]   hi_v,
    output logic [2:0][COORD_WIDTH-1:0]        box_min,
    output logic [2:0][COORD_WIDTH-1:0]        box_max,
    output logic                               empty
);
    import sba_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    logic signed [CW-1:0] min_reg [3];
    logic signed [CW-1:0] max_reg [3];
    logic                 empty_reg;

    // The box registers double as the output payload; they change only on
    // reset or when a result is loaded.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                min_reg[i] <= CMAX;
                max_reg[i] <= CMIN;
            end
            empty_reg <= 1'b1;
        end else if (ctl.load_out) begin
            unique case (mode)
                MODE_CLEAR: begin
                    for (int i = 0; i < 3; i++) begin
                        min_reg[i] <= CMAX;
                        max_reg[i] <= CMIN;
                    end
                    empty_reg <= 1'b1;
                end
                MODE_POINT, MODE_SPHERE, MODE_AXIAL, MODE_INST_BOX: begin
                    for (int i = 0; i < 3; i++) begin
                        if ($signed(lo_v[i]) < min_reg[i]) begin
                            min_reg[i] <= $signed(lo_v[i]);
                        end
                        if ($signed(hi_v[i]) > max_reg[i]) begin
                            max_reg[i] <= $signed(hi_v[i]);
                        end
                    end
                    empty_reg <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            box_min[i] = min_reg[i];
            box_max[i] = max_reg[i];
        end
    end

    assign empty = empty_reg;

endmodule

`default_nettype wire

>>> rtl/scene_bounds_accumulator.sv
// Top level of the scene bounds accumulator: input conditioning, instance
// matrix, pipeline control, three axis lanes and the merge stage.
// Depends on sba_pkg, sba_lane and sba_merge.
//
//  Channel   Ports                       Direction  Carries
//  input     s_valid s_ready s_item      in         one geometry item
//  result    m_valid m_ready m_item      out        box and empty flag
//
// One transaction is taken every cycle while the pipeline is not held; a result
// is presented once its item has passed the register groups in turn: the
// products, then the corners, then the merge into the box.
// The matrix is written as a row load transaction is taken; later items see it.
// Reset clears the box to empty, restores an identity matrix and empties the
// pipeline. Each stage holds only while the stage after it is full and held,
// so bubbles close up and input is taken while a result waits.
`default_nettype none

module scene_bounds_accumulator #(
    parameter int COORD_WIDTH = sba_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = sba_pkg::FRAC_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire sba_pkg::sba_in_t  s_item,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output sba_pkg::sba_out_t      m_item
);
    import sba_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int WW = (CW > FIELD_W) ? CW : FIELD_W;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] ONE  = CW'(1) << FRAC_BITS;

    // Saturate a port field to the coordinate range.
    function automatic logic signed [CW-1:0] sat_in(input logic signed [FIELD_W-1:0] raw);
        logic signed [WW-1:0] e;
        logic signed [CW-1:0] r;
        e = WW'(raw);
        if (e > WW'(CMAX)) begin
            r = CMAX;
        end else if (e < WW'(CMIN)) begin
            r = CMIN;
        end else begin
            r = CW'(e);
        end
        return r;
    endfunction

    logic [2:0][CW-1:0] pos_v;
    logic [2:0][CW-1:0] aux_v;
    logic signed [CW-1:0] rad_c;
    logic signed [CW-1:0] hgt_c;
    logic signed [CW-1:0] half_c;

    always_comb begin
        pos_v[0] = sat_in(s_item.pos_x);
        pos_v[1] = sat_in(s_item.pos_y);
        pos_v[2] = sat_in(s_item.pos_z);
        aux_v[0] = sat_in(s_item.aux_x);
        aux_v[1] = sat_in(s_item.aux_y);
        aux_v[2] = sat_in(s_item.aux_z);
        rad_c    = sat_in(s_item.radius);
        hgt_c    = sat_in(s_item.height);
        half_c   = hgt_c >>> 1;
    end

    // Pipeline occupancy and load strobes.
    logic       v_a_reg;
    logic       v_b_reg;
    logic       v_o_reg;
    logic [2:0] mode_a_reg;
    logic [2:0] mode_b_reg;
    sba_ctl_t   ctl;
    logic       free_o;
    logic       free_b;
    logic       free_a;

    always_comb begin
        free_o       = !v_o_reg || m_ready;
        free_b       = !v_b_reg || free_o;
        free_a       = !v_a_reg || free_b;
        ctl.load_a   = s_valid && free_a;
        ctl.load_b   = v_a_reg && free_b;
        ctl.load_out = v_b_reg && free_o;
    end

    assign s_ready = free_a;
    assign m_valid = v_o_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
            v_o_reg <= 1'b0;
        end else begin
            if (free_a) begin
                v_a_reg <= s_valid;
            end
            if (free_b) begin
                v_b_reg <= v_a_reg;
            end
            if (free_o) begin
                v_o_reg <= v_b_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_a) begin
            mode_a_reg <= s_item.mode;
        end
        if (ctl.load_b) begin
            mode_b_reg <= mode_a_reg;
        end
    end

    // Instance matrix, row major 3x4, written by row load transactions.
    logic [2:0][3:0][CW-1:0] matrix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 4; c++) begin
                    matrix_reg[r][c] <= (r == c) ? ONE : '0;
                end
            end
        end else if (ctl.load_a && s_item.mode == MODE_ROW_LOAD
                     && s_item.matrix_row < MATRIX_ROWS) begin
            matrix_reg[s_item.matrix_row][0] <= pos_v[0];
            matrix_reg[s_item.matrix_row][1] <= pos_v[1];
            matrix_reg[s_item.matrix_row][2] <= pos_v[2];
            matrix_reg[s_item.matrix_row][3] <= aux_v[0];
        end
    end

    // Axis lanes.
    logic [2:0][CW-1:0] lo_v;
    logic [2:0][CW-1:0] hi_v;

    for (genvar g = 0; g < 3; g++) begin : g_lane
        sba_lane #(
            .COORD_WIDTH (COORD_WIDTH),
            .FRAC_BITS   (FRAC_BITS),
            .LANE        (g)
        ) u_lane (
            .aclk  (aclk),
            .ctl   (ctl),
            .mode  (s_item.mode),
            .pos_v (pos_v),
            .aux_v (aux_v),
            .rad   (rad_c),
            .half  (half_c),
            .mrow  (matrix_reg[g]),
            .lo    (lo_v[g]),
            .hi    (hi_v[g])
        );
    end

    // Merge into the scene box.
    logic [2:0][CW-1:0] box_min;
    logic [2:0][CW-1:0] box_max;
    logic               empty;

    sba_merge #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .mode    (mode_b_reg),
        .lo_v    (lo_v),
        .hi_v    (hi_v),
        .box_min (box_min),
        .box_max (box_max),
        .empty   (empty)
    );

    always_comb begin
        m_item.min_x    = FIELD_W'($signed(box_min[0]));
        m_item.min_y    = FIELD_W'($signed(box_min[1]));
        m_item.min_z    = FIELD_W'($signed(box_min[2]));
        m_item.max_x    = FIELD_W'($signed(box_max[0]));
        m_item.max_y    = FIELD_W'($signed(box_max[1]));
        m_item.max_z    = FIELD_W'($signed(box_max[2]));
        m_item.is_empty = empty;
    end

endmodule

`default_nettype wire

>>> tb/sv/tb_scene_bounds_accumulator.sv
// Testbench for scene_bounds_accumulator: random and directed geometry items
// checked against a behavioral box-union predictor held in a scoreboard class.
// Depends on sba_pkg and the scene_bounds_accumulator RTL.
`timescale 1ns / 1ps

module tb_scene_bounds_accumulator;
    import sba_pkg::*;

    localparam longint CMAX = 64'sd2147483647;
    localparam longint CMIN = -64'sd2147483648;
    localparam longint ONE = 64'sd65536;
    localparam int CYCLE_LIMIT = 400000;

    // Box tracker with its own copy of the box and instance matrix.
    class bounds_scoreboard;
        longint box_lo[3];
        longint box_hi[3];
        longint xform[12];
        bit empty;
        sba_out_t pending[$];
        int mismatches;
        int checked;

        function void reset_state();
            for (int i = 0; i < 3; i++) begin
                box_lo[i] = CMAX;
                box_hi[i] = CMIN;
            end
            empty = 1'b1;
            for (int i = 0; i < 12; i++) xform[i] = 0;
            for (int i = 0; i < 3; i++) xform[i * 4 + i] = ONE;
            pending.delete();
            mismatches = 0;
            checked = 0;
        endfunction

        function longint clamp(longint v);
            if (v > CMAX) return CMAX;
            if (v < CMIN) return CMIN;
            return v;
        endfunction

        // Arithmetic shift rounds toward minus infinity.
        function longint qmul(longint a, longint b);
            return (a * b) >>> 16;
        endfunction

        function void grow(longint lo[3], longint hi[3]);
            for (int i = 0; i < 3; i++) begin
                if (lo[i] < box_lo[i]) box_lo[i] = lo[i];
                if (hi[i] > box_hi[i]) box_hi[i] = hi[i];
            end
            empty = 1'b0;
        endfunction

        // Apply one accepted input transaction and queue its expected result.
        function void note_item(sba_in_t it);
            longint p[3], a[3], lo[3], hi[3], c[3];
            longint r, half, off, p0, p1, t;
            sba_out_t res;
            p[0] = it.pos_x; p[1] = it.pos_y; p[2] = it.pos_z;
            a[0] = it.aux_x; a[1] = it.aux_y; a[2] = it.aux_z;
            r = it.radius;
            case (it.mode)
                MODE_CLEAR: begin
                    for (int i = 0; i < 3; i++) begin
                        box_lo[i] = CMAX;
                        box_hi[i] = CMIN;
                    end
                    empty = 1'b1;
                end
                MODE_POINT: grow(p, p);
                MODE_SPHERE: begin
                    for (int i = 0; i < 3; i++) begin
                        lo[i] = clamp(p[i] - r);
                        hi[i] = clamp(p[i] + r);
                    end
                    grow(lo, hi);
                end
                MODE_AXIAL: begin
                    half = longint'(it.height) >>> 1;
                    for (int i = 0; i < 3; i++) begin
                        off = qmul(a[i], half);
                        p0 = clamp(p[i] - off);
                        p1 = clamp(p[i] + off);
                        lo[i] = clamp(((p0 < p1) ? p0 : p1) - r);
                        hi[i] = clamp(((p0 < p1) ? p1 : p0) + r);
                    end
                    grow(lo, hi);
                end
                MODE_ROW_LOAD: begin
                    if (it.matrix_row < MATRIX_ROWS) begin
                        for (int k = 0; k < 3; k++) xform[it.matrix_row * 4 + k] = p[k];
                        xform[it.matrix_row * 4 + 3] = a[0];
                    end
                end
                MODE_INST_BOX: begin
                    for (int i = 0; i < 3; i++) begin
                        lo[i] = CMAX;
                        hi[i] = CMIN;
                    end
                    for (int k = 0; k < 8; k++) begin
                        c[0] = k[0] ? a[0] : p[0];
                        c[1] = k[1] ? a[1] : p[1];
                        c[2] = k[2] ? a[2] : p[2];
                        for (int i = 0; i < 3; i++) begin
                            t = clamp(qmul(xform[i * 4], c[0]) + qmul(xform[i * 4 + 1], c[1])
                                      + qmul(xform[i * 4 + 2], c[2]) + xform[i * 4 + 3]);
                            if (t < lo[i]) lo[i] = t;
                            if (t > hi[i]) hi[i] = t;
                        end
                    end
                    grow(lo, hi);
                end
                default: ;
            endcase
            res.min_x = box_lo[0][31:0];
            res.min_y = box_lo[1][31:0];
            res.min_z = box_lo[2][31:0];
            res.max_x = box_hi[0][31:0];
            res.max_y = box_hi[1][31:0];
            res.max_z = box_hi[2][31:0];
            res.is_empty = empty;
            pending.insert(pending.size(), res);
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_result(sba_out_t got);
            sba_out_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result transaction: %p", got);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Result mismatch %0d:", checked);
                    $display("  expected %p", want);
                    $display("  actual   %p", got);
                end
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    sba_in_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    sba_out_t m_item;

    bounds_scoreboard sb;
    int cycle_count = 0;
    int stall_phase = 0;
    int gap_left = 0;
    int burst_left = 0;
    int sent = 0;

    always #10 aclk = ~aclk;

    scene_bounds_accumulator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    // Watchdog on total run length.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver stalls on a repeating pattern with random stretches.
    always @(posedge aclk) begin
        stall_phase <= stall_phase + 1;
        if (!aresetn) m_ready <= 1'b0;
        else if (stall_phase[9:8] == 2'd0) m_ready <= 1'b1;
        else m_ready <= (stall_phase % 7 < 4) || ($urandom_range(0, 3) == 0);
    end

    // Check every accepted result transaction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_item);
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 8) << 16;
            3, 4: return $urandom_range(0, 1 << 22) - (1 << 21);
            default: return $urandom;
        endcase
    endfunction

    function automatic sba_in_t rand_item();
        sba_in_t it;
        int pick;
        it.pos_x = rand_coord(); it.pos_y = rand_coord(); it.pos_z = rand_coord();
        it.aux_x = rand_coord(); it.aux_y = rand_coord(); it.aux_z = rand_coord();
        it.radius = rand_coord(); it.height = rand_coord();
        it.matrix_row = $urandom_range(0, 3);
        pick = $urandom_range(0, 99);
        if (pick < 4) it.mode = MODE_CLEAR;
        else if (pick < 24) it.mode = MODE_POINT;
        else if (pick < 42) it.mode = MODE_SPHERE;
        else if (pick < 62) it.mode = MODE_AXIAL;
        else if (pick < 74) it.mode = MODE_ROW_LOAD;
        else if (pick < 96) it.mode = MODE_INST_BOX;
        else it.mode = $urandom_range(6, 7);
        return it;
    endfunction

    // Present one item and hold it until the handshake completes.
    task automatic send_item(sba_in_t it);
        s_item <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
        sent++;
    endtask

    // Send with bursty gaps; valid drops only between bursts.
    task automatic send_paced(sba_in_t it);
        if (burst_left == 0) begin
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 20);
            if (gap_left > 0) begin
                s_valid <= 1'b0;
                repeat (gap_left) @(posedge aclk);
            end
        end
        burst_left--;
        send_item(it);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic sba_in_t mk(logic [2:0] md, logic [1:0] row, logic [31:0] px,
                                   logic [31:0] py, logic [31:0] pz, logic [31:0] ax,
                                   logic [31:0] ay, logic [31:0] az, logic [31:0] rd,
                                   logic [31:0] ht);
        sba_in_t it;
        it = '{md, row, px, py, pz, ax, ay, az, rd, ht};
        return it;
    endfunction

    initial begin
        sb = new();
        sb.reset_state();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items: extremes, every mode, inverted boxes, ignored row.
        send_item(mk(MODE_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(MODE_POINT, 3, 32'h7fffffff, 32'h80000000, 32'hffffffff,
                     32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff));
        send_item(mk(MODE_SPHERE, 0, 32'h7fffffff, 32'h80000000, 1, 0, 0, 0,
                     32'h7fffffff, 0));
        send_item(mk(MODE_SPHERE, 0, 5 << 16, 0, 0, 0, 0, 0, 32'hfffe0000, 0));
        send_item(mk(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(MODE_SPHERE, 0, 0, 0, 0, 0, 0, 0, 32'hfffe0000, 0));
        send_item(mk(MODE_AXIAL, 0, 0, 1 << 16, 0, 1 << 16, 32'hffff0000, 0, 1 << 15,
                     3 << 16));
        send_item(mk(MODE_AXIAL, 0, 32'h7fff0000, 0, 32'h80000000, 32'h7fffffff,
                     32'h80000000, 32'h7fffffff, 32'h80000000, 32'hffffffff));
        send_item(mk(MODE_AXIAL, 0, 0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000,
                     0, 32'h7fffffff));
        send_item(mk(MODE_INST_BOX, 0, 32'hffff0000, 32'hffff0000, 32'hffff0000,
                     1 << 16, 1 << 16, 1 << 16, 0, 0));
        send_item(mk(MODE_INST_BOX, 0, 9 << 16, 9 << 16, 9 << 16, 2 << 16, 2 << 16,
                     2 << 16, 0, 0));
        send_item(mk(MODE_ROW_LOAD, 0, 0, 2 << 16, 0, 32'h7fffffff, 0, 0, 0, 0));
        send_item(mk(MODE_ROW_LOAD, 1, 32'h80000000, 0, 32'h7fffffff, 32'h80000000,
                     0, 0, 0, 0));
        send_item(mk(MODE_ROW_LOAD, 2, 0, 0, 32'hffff8000, 3 << 16, 0, 0, 0, 0));
        send_item(mk(MODE_ROW_LOAD, 3, 32'h12345678, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(MODE_INST_BOX, 0, 32'h80000000, 32'h80000000, 32'h80000000,
                     32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0));
        send_item(mk(3'd6, 0, 1, 1, 1, 1, 1, 1, 1, 1));
        send_item(mk(3'd7, 0, 1, 1, 1, 1, 1, 1, 1, 1));
        send_item(mk(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(MODE_INST_BOX, 0, 1 << 16, 1 << 16, 1 << 16, 4 << 16, 4 << 16,
                     4 << 16, 0, 0));

        // Sender holds off until every result is back.
        drain();

        // Random stream with bursty sender.
        while (sent < 670) begin
            send_paced(rand_item());
            if (sent == 350) drain();
        end
        drain();

        $display("Covered %0d items over all modes with %0d results checked.",
                 sent, sb.checked);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
